// ===== src/cst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants for the C subset tokenizer
// Result records, queue entries, token codes and character class helpers.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int unsigned WORD_MAX     = 31;
  localparam int unsigned TEXT_MAX     = 255;
  localparam int unsigned STRING_SLOTS = 128;

  localparam int unsigned WLEN_W = $clog2(WORD_MAX + 1);
  localparam int unsigned TLEN_W = $clog2(TEXT_MAX + 1);
  localparam int unsigned SCNT_W = $clog2(STRING_SLOTS + 1);

  localparam logic [31:0] STR_BASE = 32'h4000_0000;

  localparam logic [4:0] TK_EOF    = 5'd0;
  localparam logic [4:0] TK_INT    = 5'd1;
  localparam logic [4:0] TK_RET    = 5'd2;
  localparam logic [4:0] TK_IF     = 5'd3;
  localparam logic [4:0] TK_ELSE   = 5'd4;
  localparam logic [4:0] TK_LOOP   = 5'd5;
  localparam logic [4:0] TK_NAME   = 5'd6;
  localparam logic [4:0] TK_NUM    = 5'd7;
  localparam logic [4:0] TK_LCURLY = 5'd8;
  localparam logic [4:0] TK_RCURLY = 5'd9;
  localparam logic [4:0] TK_LPAREN = 5'd10;
  localparam logic [4:0] TK_RPAREN = 5'd11;
  localparam logic [4:0] TK_SEMI   = 5'd12;
  localparam logic [4:0] TK_SET    = 5'd13;
  localparam logic [4:0] TK_PLUS   = 5'd14;
  localparam logic [4:0] TK_SUB    = 5'd15;
  localparam logic [4:0] TK_STAR   = 5'd16;
  localparam logic [4:0] TK_SLASH  = 5'd17;
  localparam logic [4:0] TK_PCT    = 5'd18;
  localparam logic [4:0] TK_LT     = 5'd19;
  localparam logic [4:0] TK_LE     = 5'd20;
  localparam logic [4:0] TK_GT     = 5'd21;
  localparam logic [4:0] TK_GE     = 5'd22;
  localparam logic [4:0] TK_EQ     = 5'd23;
  localparam logic [4:0] TK_NE     = 5'd24;
  localparam logic [4:0] TK_SEP    = 5'd25;

  typedef struct packed {
    logic        kind;
    logic [4:0]  tk;
    logic [31:0] value;
    logic [7:0]  ch;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

  function automatic res_t mk_tok(input logic [4:0] tk, input logic [31:0] v);
    res_t r;
    r.kind  = 1'b0;
    r.tk    = tk;
    r.value = v;
    r.ch    = 8'd0;
    return r;
  endfunction

  function automatic res_t mk_chr(input logic [7:0] c);
    res_t r;
    r.kind  = 1'b1;
    r.tk    = TK_EOF;
    r.value = 32'd0;
    r.ch    = c;
    return r;
  endfunction

  function automatic logic [4:0] kw_code(input logic [5:0][7:0] p,
                                         input logic [WLEN_W-1:0] len);
    logic [4:0] tk;
    tk = TK_NAME;
    if (len == WLEN_W'(3) && p[0] == "i" && p[1] == "n" && p[2] == "t") tk = TK_INT;
    else if (len == WLEN_W'(6) && p[0] == "r" && p[1] == "e" && p[2] == "t" &&
             p[3] == "u" && p[4] == "r" && p[5] == "n") tk = TK_RET;
    else if (len == WLEN_W'(2) && p[0] == "i" && p[1] == "f") tk = TK_IF;
    else if (len == WLEN_W'(4) && p[0] == "e" && p[1] == "l" && p[2] == "s" &&
             p[3] == "e") tk = TK_ELSE;
    else if (len == WLEN_W'(5) && p[0] == "w" && p[1] == "h" && p[2] == "i" &&
             p[3] == "l" && p[4] == "e") tk = TK_LOOP;
    return tk;
  endfunction

  function automatic logic [4:0] single_tok(input logic [7:0] c);
    logic [4:0] tk;
    case (c)
      "{":     tk = TK_LCURLY;
      "}":     tk = TK_RCURLY;
      "(":     tk = TK_LPAREN;
      ")":     tk = TK_RPAREN;
      ";":     tk = TK_SEMI;
      ",":     tk = TK_SEP;
      "+":     tk = TK_PLUS;
      "-":     tk = TK_SUB;
      "*":     tk = TK_STAR;
      "%":     tk = TK_PCT;
      default: tk = TK_EOF;
    endcase
    return tk;
  endfunction

  function automatic logic [4:0] held_single(input logic [7:0] h);
    logic [4:0] tk;
    case (h)
      "=":     tk = TK_SET;
      "<":     tk = TK_LT;
      ">":     tk = TK_GT;
      "/":     tk = TK_SLASH;
      default: tk = TK_EOF;
    endcase
    return tk;
  endfunction

endpackage
`default_nettype wire

// ===== src/c_subset_tokenizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// c_subset_tokenizer: streaming lexer for a small C subset
// A result is written into the queue when its byte is accepted.
// Throughput: one byte per cycle while the queue is not full; a transaction
// with two results holds the output for both; the two-entry queue absorbs such bursts.
// Reset: asynchronous, clears scan state, queue and sequencer.
// ----------------------------------------------------------------------------
module c_subset_tokenizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  source_byte_i,
  input  wire logic        end_of_source_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             result_kind_o,
  output logic [4:0]       token_kind_o,
  output logic [31:0]      token_value_o,
  output logic [7:0]       text_char_o,
  output logic             last_of_step_o
);
  import cst_pkg::*;

  logic   push, full, hvalid, pop;
  entry_t entry, head;

  cst_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .source_byte_i, .end_of_source_i,
    .q_full_i(full), .q_push_o(push), .q_entry_o(entry)
  );

  cst_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .entry_i(entry), .full_o(full),
    .valid_o(hvalid), .head_o(head), .pop_i(pop)
  );

  cst_back u_back (
    .clk_i, .rst_ni, .head_valid_i(hvalid), .head_i(head), .pop_o(pop),
    .out_valid_o, .out_ready_i, .result_kind_o, .token_kind_o, .token_value_o,
    .text_char_o, .last_of_step_o
  );

endmodule
`default_nettype wire

// ===== src/cst_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cst_front: scanner front end
// Classifies one byte per cycle while the queue is not full, updates scan state
// and packs up to two results of the transaction into one queue entry.
// ----------------------------------------------------------------------------
module cst_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      source_byte_i,
  input  wire logic            end_of_source_i,
  input  wire logic            q_full_i,
  output logic                 q_push_o,
  output cst_pkg::entry_t      q_entry_o
);
  import cst_pkg::*;

  typedef enum logic [2:0] {
    M_NORMAL, M_WORD, M_NUMBER, M_STRING, M_ESCAPE, M_COMMENT, M_SWALLOW
  } mode_e;

  mode_e              mode_q, mode_d;
  logic [7:0]         held_q, held_d;
  logic [5:0][7:0]    prefix_q, prefix_d;
  logic [WLEN_W-1:0]  wlen_q, wlen_d;
  logic [31:0]        acc_q, acc_d;
  logic [TLEN_W-1:0]  tlen_q, tlen_d;
  logic [SCNT_W-1:0]  scnt_q, scnt_d;
  res_t [1:0]         res;
  logic [1:0]         n;
  logic               accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic [7:0] c;
    logic       nb;
    logic [4:0] tk;
    c        = source_byte_i;
    nb       = 1'b0;
    tk       = TK_EOF;
    mode_d   = mode_q;
    held_d   = held_q;
    prefix_d = prefix_q;
    wlen_d   = wlen_q;
    acc_d    = acc_q;
    tlen_d   = tlen_q;
    scnt_d   = scnt_q;
    res      = '0;
    n        = 2'd0;

    if (end_of_source_i) begin
      case (mode_q)
        M_NORMAL: begin
          tk = held_single(held_q);
          if (tk != TK_EOF) begin
            res[0] = mk_tok(tk, 32'd0);
            n = 2'd1;
          end
        end
        M_WORD: begin
          res[0] = mk_tok(kw_code(prefix_q, wlen_q), 32'd0);
          n = 2'd1;
        end
        M_NUMBER: begin
          res[0] = mk_tok(TK_NUM, acc_q);
          n = 2'd1;
        end
        M_STRING, M_ESCAPE: begin
          res[0] = mk_tok(TK_NUM, STR_BASE + 32'(scnt_q));
          n = 2'd1;
        end
        default: ;
      endcase
      res[n[0]] = mk_tok(TK_EOF, 32'd0);
      n = n + 2'd1;
      mode_d   = M_NORMAL;
      held_d   = 8'd0;
      prefix_d = '0;
      wlen_d   = '0;
      acc_d    = 32'd0;
      tlen_d   = '0;
      scnt_d   = '0;
    end else begin
      case (mode_q)
        M_NORMAL: begin
          if (held_q != 8'd0) begin
            held_d = 8'd0;
            if (c == "=" && (held_q == "=" || held_q == "!" || held_q == "<" ||
                             held_q == ">")) begin
              case (held_q)
                "=":     tk = TK_EQ;
                "!":     tk = TK_NE;
                "<":     tk = TK_LE;
                default: tk = TK_GE;
              endcase
              res[0] = mk_tok(tk, 32'd0);
              n = 2'd1;
            end else if (held_q == "/" && c == "/") begin
              mode_d = M_COMMENT;
            end else begin
              tk = held_single(held_q);
              if (tk != TK_EOF) begin
                res[0] = mk_tok(tk, 32'd0);
                n = 2'd1;
              end
              nb = 1'b1;
            end
          end else begin
            nb = 1'b1;
          end
        end
        M_WORD: begin
          if (is_alpha(c) || is_digit(c)) begin
            res[0] = mk_chr(c);
            n = 2'd1;
            if (wlen_q < WLEN_W'(6)) prefix_d[wlen_q[2:0]] = c;
            wlen_d = wlen_q + WLEN_W'(1);
            if (wlen_d >= WLEN_W'(WORD_MAX)) begin
              res[1] = mk_tok(kw_code(prefix_d, wlen_d), 32'd0);
              n = 2'd2;
              mode_d   = M_NORMAL;
              wlen_d   = '0;
              prefix_d = '0;
            end
          end else begin
            res[0] = mk_tok(kw_code(prefix_q, wlen_q), 32'd0);
            n = 2'd1;
            wlen_d   = '0;
            prefix_d = '0;
            nb = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit(c)) begin
            acc_d = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + 32'(c - "0");
          end else begin
            res[0] = mk_tok(TK_NUM, acc_q);
            n = 2'd1;
            acc_d = 32'd0;
            nb = 1'b1;
          end
        end
        M_STRING, M_ESCAPE: begin
          if (mode_q == M_STRING && c == 8'h22) begin
            res[0] = mk_tok(TK_NUM, STR_BASE + 32'(scnt_q));
            n = 2'd1;
            if (scnt_q < SCNT_W'(STRING_SLOTS)) scnt_d = scnt_q + SCNT_W'(1);
            tlen_d = '0;
            mode_d = M_NORMAL;
          end else if (mode_q == M_STRING && c == 8'h5c) begin
            mode_d = M_ESCAPE;
          end else begin
            res[0] = mk_chr((mode_q == M_ESCAPE && c == "n") ? 8'h0a : c);
            n = 2'd1;
            tlen_d = tlen_q + TLEN_W'(1);
            mode_d = M_STRING;
            if (tlen_d >= TLEN_W'(TEXT_MAX)) begin
              res[1] = mk_tok(TK_NUM, STR_BASE + 32'(scnt_q));
              n = 2'd2;
              if (scnt_q < SCNT_W'(STRING_SLOTS)) scnt_d = scnt_q + SCNT_W'(1);
              tlen_d = '0;
              mode_d = M_SWALLOW;
            end
          end
        end
        M_COMMENT: begin
          if (c == 8'h0a) mode_d = M_NORMAL;
        end
        M_SWALLOW: begin
          mode_d = M_NORMAL;
          if (c != 8'h22) nb = 1'b1;
        end
        default: mode_d = M_NORMAL;
      endcase

      if (nb) begin
        mode_d = M_NORMAL;
        if (is_space(c)) begin
          mode_d = M_NORMAL;
        end else if (c == 8'h22) begin
          mode_d = M_STRING;
          tlen_d = '0;
        end else if (is_alpha(c)) begin
          mode_d      = M_WORD;
          prefix_d    = '0;
          prefix_d[0] = c;
          wlen_d      = WLEN_W'(1);
          if (n != 2'd2) begin
            res[n[0]] = mk_chr(c);
            n = n + 2'd1;
          end
        end else if (is_digit(c)) begin
          mode_d = M_NUMBER;
          acc_d  = 32'(c - "0");
        end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "/") begin
          held_d = c;
        end else begin
          tk = single_tok(c);
          if (tk != TK_EOF && n != 2'd2) begin
            res[n[0]] = mk_tok(tk, 32'd0);
            n = n + 2'd1;
          end
        end
      end
    end
  end

  assign q_push_o     = accept && (n != 2'd0);
  assign q_entry_o.two = (n == 2'd2);
  assign q_entry_o.r0  = res[0];
  assign q_entry_o.r1  = res[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_NORMAL;
      held_q   <= 8'd0;
      prefix_q <= '0;
      wlen_q   <= '0;
      acc_q    <= 32'd0;
      tlen_q   <= '0;
      scnt_q   <= '0;
    end else if (accept) begin
      mode_q   <= mode_d;
      held_q   <= held_d;
      prefix_q <= prefix_d;
      wlen_q   <= wlen_d;
      acc_q    <= acc_d;
      tlen_q   <= tlen_d;
      scnt_q   <= scnt_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/cst_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cst_queue: two-entry queue between scanner and result sequencer
// Holds packed result groups so front and back stall independently.
// ----------------------------------------------------------------------------
module cst_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  cst_pkg::entry_t      entry_i,
  output logic                 full_o,
  output logic                 valid_o,
  output cst_pkg::entry_t      head_o,
  input  wire logic            pop_i
);
  import cst_pkg::*;

  entry_t     mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wr_q != rd_q)) else $error("pointers disagree with count");
`endif

endmodule
`default_nettype wire

// ===== src/cst_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cst_back: result sequencer
// Presents the one or two results of each queue entry in order and marks
// the final result of each transaction.
// ----------------------------------------------------------------------------
module cst_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            head_valid_i,
  input  cst_pkg::entry_t      head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 result_kind_o,
  output logic [4:0]           token_kind_o,
  output logic [31:0]          token_value_o,
  output logic [7:0]           text_char_o,
  output logic                 last_of_step_o
);
  import cst_pkg::*;

  logic phase_q;
  res_t cur;
  logic fire;

  assign cur            = phase_q ? head_i.r1 : head_i.r0;
  assign out_valid_o    = head_valid_i;
  assign result_kind_o  = cur.kind;
  assign token_kind_o   = cur.tk;
  assign token_value_o  = cur.value;
  assign text_char_o    = cur.ch;
  assign last_of_step_o = phase_q || !head_i.two;
  assign fire           = head_valid_i && out_ready_i;
  assign pop_o          = fire && last_of_step_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else if (fire) begin
      phase_q <= !last_of_step_o;
    end
  end

`ifndef SYNTHESIS
  a_phase_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (head_valid_i && head_i.two)) else $error("second half without pair");
  a_phase_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && phase_q) |=> !phase_q) else $error("phase did not return");
  a_first_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !phase_q && head_i.two) |-> !pop_o) else $error("pair popped early");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_c_subset_tokenizer.sv =====
// ----------------------------------------------------------------------------
// tb_c_subset_tokenizer: self-checking bench for the C subset tokenizer
// Feeds directed and random source text, models the lexer in the bench and
// compares every output transaction with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_c_subset_tokenizer;
  import cst_pkg::*;

  typedef enum logic [2:0] {
    SM_NORMAL, SM_WORD, SM_NUMBER, SM_STRING, SM_ESCAPE, SM_COMMENT, SM_SWALLOW
  } scan_e;

  typedef struct packed {
    logic        kind;
    logic [4:0]  tk;
    logic [31:0] value;
    logic [7:0]  ch;
    logic        last;
  } lex_res_t;

  typedef struct packed {
    logic [7:0] c;
    logic       eos;
    logic       chk;
    logic [4:0] tk;
    logic [31:0] value;
  } stim_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  source_byte_i = 8'd0;
  logic        end_of_source_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        result_kind_o;
  logic [4:0]  token_kind_o;
  logic [31:0] token_value_o;
  logic [7:0]  text_char_o;
  logic        last_of_step_o;

  c_subset_tokenizer DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // lexer model state
  scan_e          lx_mode;
  logic [7:0]     lx_held;
  logic [5:0][7:0] lx_prefix;
  int unsigned    lx_wlen;
  logic [31:0]    lx_num;
  int unsigned    lx_tlen;
  int unsigned    lx_scnt;
  lex_res_t       step_res[$];
  lex_res_t       token_q[$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          stim_done = 1'b0;
  stim_t       stim_q[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("ERR @%0d %s got %0h expected %0h", cycles, what, got, exp);
    errors++;
  endtask

  function automatic void lx_reset();
    lx_mode = SM_NORMAL; lx_held = 8'd0; lx_prefix = '0;
    lx_wlen = 0; lx_num = 32'd0; lx_tlen = 0; lx_scnt = 0;
  endfunction

  function automatic void push_res(input logic k, input logic [4:0] tk,
                                   input logic [31:0] v, input logic [7:0] ch);
    lex_res_t r;
    if (step_res.size() >= 2) return;
    r = '{kind: k, tk: tk, value: v, ch: ch, last: 1'b0};
    step_res.push_back(r);
  endfunction

  function automatic bit c_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction
  function automatic bit c_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void flush_word();
    logic [4:0] tk;
    tk = TK_NAME;
    if (lx_wlen == 3 && lx_prefix[2:0] == {"t","n","i"}) tk = TK_INT;
    else if (lx_wlen == 6 && lx_prefix == {"n","r","u","t","e","r"}) tk = TK_RET;
    else if (lx_wlen == 2 && lx_prefix[1:0] == {"f","i"}) tk = TK_IF;
    else if (lx_wlen == 4 && lx_prefix[3:0] == {"e","s","l","e"}) tk = TK_ELSE;
    else if (lx_wlen == 5 && lx_prefix[4:0] == {"e","l","i","h","w"}) tk = TK_LOOP;
    push_res(1'b0, tk, 32'd0, 8'd0);
    lx_mode = SM_NORMAL; lx_wlen = 0; lx_prefix = '0;
  endfunction

  function automatic void word_char(input logic [7:0] c);
    push_res(1'b1, TK_EOF, 32'd0, c);
    if (lx_wlen < 6) lx_prefix[3'(lx_wlen)] = c;
    lx_wlen++;
    if (lx_wlen >= WORD_MAX) flush_word();
  endfunction

  function automatic void flush_string();
    int unsigned idx;
    idx = lx_scnt < STRING_SLOTS ? lx_scnt : STRING_SLOTS;
    if (lx_scnt < STRING_SLOTS) lx_scnt++;
    push_res(1'b0, TK_NUM, STR_BASE + idx, 8'd0);
    lx_tlen = 0;
  endfunction

  function automatic void text_char(input logic [7:0] c);
    push_res(1'b1, TK_EOF, 32'd0, c);
    lx_tlen++;
    if (lx_tlen >= TEXT_MAX) begin
      flush_string();
      lx_mode = SM_SWALLOW;
    end else begin
      lx_mode = SM_STRING;
    end
  endfunction

  function automatic void held_tok(input logic [7:0] h);
    case (h)
      "=": push_res(1'b0, TK_SET, 32'd0, 8'd0);
      "<": push_res(1'b0, TK_LT, 32'd0, 8'd0);
      ">": push_res(1'b0, TK_GT, 32'd0, 8'd0);
      "/": push_res(1'b0, TK_SLASH, 32'd0, 8'd0);
      default: ;
    endcase
  endfunction

  function automatic void plain_byte(input logic [7:0] c);
    lx_mode = SM_NORMAL;
    if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) return;
    if (c == "\"") begin
      lx_mode = SM_STRING; lx_tlen = 0; return;
    end
    if (c_alpha(c)) begin
      lx_mode = SM_WORD; lx_wlen = 0; lx_prefix = '0;
      word_char(c);
      return;
    end
    if (c_digit(c)) begin
      lx_mode = SM_NUMBER; lx_num = 32'(c - "0"); return;
    end
    case (c)
      "=", "!", "<", ">", "/": lx_held = c;
      "{": push_res(1'b0, TK_LCURLY, 32'd0, 8'd0);
      "}": push_res(1'b0, TK_RCURLY, 32'd0, 8'd0);
      "(": push_res(1'b0, TK_LPAREN, 32'd0, 8'd0);
      ")": push_res(1'b0, TK_RPAREN, 32'd0, 8'd0);
      ";": push_res(1'b0, TK_SEMI, 32'd0, 8'd0);
      ",": push_res(1'b0, TK_SEP, 32'd0, 8'd0);
      "+": push_res(1'b0, TK_PLUS, 32'd0, 8'd0);
      "-": push_res(1'b0, TK_SUB, 32'd0, 8'd0);
      "*": push_res(1'b0, TK_STAR, 32'd0, 8'd0);
      "%": push_res(1'b0, TK_PCT, 32'd0, 8'd0);
      default: ;
    endcase
  endfunction

  function automatic bit held_pair(input logic [7:0] c);
    logic [7:0] h;
    h = lx_held;
    lx_held = 8'd0;
    if (c == "=") begin
      case (h)
        "=": begin push_res(1'b0, TK_EQ, 32'd0, 8'd0); return 1'b1; end
        "!": begin push_res(1'b0, TK_NE, 32'd0, 8'd0); return 1'b1; end
        "<": begin push_res(1'b0, TK_LE, 32'd0, 8'd0); return 1'b1; end
        ">": begin push_res(1'b0, TK_GE, 32'd0, 8'd0); return 1'b1; end
        default: ;
      endcase
    end
    if (h == "/" && c == "/") begin
      lx_mode = SM_COMMENT; return 1'b1;
    end
    held_tok(h);
    return 1'b0;
  endfunction

  function automatic void lex_step(input logic [7:0] c, input logic eos);
    step_res.delete();
    if (eos) begin
      case (lx_mode)
        SM_NORMAL: held_tok(lx_held);
        SM_WORD: flush_word();
        SM_NUMBER: push_res(1'b0, TK_NUM, lx_num, 8'd0);
        SM_STRING, SM_ESCAPE: flush_string();
        default: ;
      endcase
      push_res(1'b0, TK_EOF, 32'd0, 8'd0);
      lx_reset();
    end else begin
      case (lx_mode)
        SM_NORMAL: if (!(lx_held != 8'd0 && held_pair(c))) plain_byte(c);
        SM_WORD: begin
          if (c_alpha(c) || c_digit(c)) word_char(c);
          else begin
            flush_word(); plain_byte(c);
          end
        end
        SM_NUMBER: begin
          if (c_digit(c)) lx_num = lx_num * 32'd10 + 32'(c - "0");
          else begin
            push_res(1'b0, TK_NUM, lx_num, 8'd0); lx_num = 32'd0; plain_byte(c);
          end
        end
        SM_STRING: begin
          if (c == "\"") begin
            flush_string(); lx_mode = SM_NORMAL;
          end else if (c == "\\") lx_mode = SM_ESCAPE;
          else text_char(c);
        end
        SM_ESCAPE: text_char(c == "n" ? 8'd10 : c);
        SM_COMMENT: if (c == 8'h0a) lx_mode = SM_NORMAL;
        SM_SWALLOW: begin
          lx_mode = SM_NORMAL;
          if (c != "\"") plain_byte(c);
        end
        default: lx_mode = SM_NORMAL;
      endcase
    end
    if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
  endfunction

  // stimulus builders
  task automatic add_b(input logic [7:0] c);
    stim_q.push_back('{c: c, eos: 1'b0, chk: 1'b0, tk: TK_EOF, value: 32'd0});
  endtask
  task automatic add_s(input string s);
    foreach (s[i]) add_b(s[i]);
  endtask
  task automatic add_eos(input logic [7:0] junk);
    stim_q.push_back('{c: junk, eos: 1'b1, chk: 1'b0, tk: TK_EOF, value: 32'd0});
  endtask
  task automatic add_chk(input logic [7:0] c, input logic eos, input logic [4:0] tk,
                         input logic [31:0] v);
    stim_q.push_back('{c: c, eos: eos, chk: 1'b1, tk: tk, value: v});
  endtask

  function automatic logic [7:0] rnd_char();
    case ($urandom_range(0, 9))
      0, 1: return 8'($urandom_range("a", "z"));
      2: return 8'($urandom_range("0", "9"));
      3: return " ";
      4: begin
        string ops;
        ops = "=!<>/{}();,+-*%\"\\_";
        return ops[$urandom_range(0, ops.len() - 1)];
      end
      5: return 8'h0a;
      6: return 8'($urandom_range(0, 255));
      7: return "=";
      8: return 8'($urandom_range("A", "Z"));
      default: return "\"";
    endcase
  endfunction

  task automatic build_random();
    string kws[5];
    int unsigned n;
    kws = '{"int", "return", "if", "else", "while"};
    while (stim_q.size() < 975) begin
      case ($urandom_range(0, 11))
        0, 1: add_s({kws[$urandom_range(0, 4)], " "});
        2: begin
          n = $urandom_range(1, 40);
          repeat (n) add_b($urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                                               : 8'($urandom_range("0", "9")));
          add_b(" ");
        end
        3: begin
          n = $urandom_range(1, 12);
          add_b(8'($urandom_range("1", "9")));
          repeat (n) add_b(8'($urandom_range("0", "9")));
          add_b(";");
        end
        4: begin
          add_b("\"");
          n = $urandom_range(0, 10);
          repeat (n) begin
            if ($urandom_range(0, 4) == 0) add_b("\\");
            add_b(8'($urandom_range(0, 255)));
          end
          add_b("\"");
        end
        5: begin
          add_s("x ");
          add_b($urandom_range(0, 1) ? "<" : ">");
          add_b($urandom_range(0, 1) ? "=" : " ");
          add_s($urandom_range(0, 1) ? "!=" : "==");
          add_s(" y");
        end
        6: begin
          add_s("//");
          repeat ($urandom_range(0, 6)) add_b(rnd_char());
          add_b(8'h0a);
        end
        7: if ($urandom_range(0, 5) == 0) add_eos(8'($urandom));
        default: repeat ($urandom_range(1, 6)) add_b(rnd_char());
      endcase
    end
    add_eos(8'hff);
  endtask

  task automatic build_directed();
    add_chk(8'h00, 1'b1, TK_EOF, 32'd0);
    add_chk("{", 1'b0, TK_LCURLY, 32'd0);
    add_s("int return if else while intx ");
    add_s("4294967296 "); add_s("0;");
    add_s("== != <= >= = < > / ! ; () } , + - * % @");
    add_s("// dropped\n");
    add_s("\"a\\n\\\"\\q\"");
    add_b(8'hff); add_b(8'h80);
    repeat (33) add_b("z");
    add_b(" ");
    add_b("\""); repeat (256) add_b("s"); add_b("\""); add_b(";");
    add_s("\"\\"); add_eos(8'h00);
    add_s("/"); add_eos(8'h00);
    add_s("//x"); add_chk(8'h00, 1'b1, TK_EOF, 32'd0);
    add_s("\""); add_b(8'h5c); add_b(8'h00); add_s("\""); add_eos(8'hff);
  endtask

  // sender
  initial begin
    stim_t s;
    int    burst;
    build_directed();
    build_random();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    lx_reset();
    @(posedge clk_i);
    while (stim_q.size() > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && stim_q.size() > 0) begin
        s = stim_q.pop_front();
        in_valid_i <= 1'b1;
        source_byte_i <= s.c;
        end_of_source_i <= s.eos;
        @(posedge clk_i);
        while (!in_ready_o) @(posedge clk_i);
        lex_step(s.c, s.eos);
        if (s.chk && (step_res[step_res.size()-1].tk != s.tk ||
                      step_res[step_res.size()-1].value != s.value))
          report("model vs table", 32'(step_res[step_res.size()-1].tk), 32'(s.tk));
        foreach (step_res[i]) token_q.push_back(step_res[i]);
        burst--;
      end
      if ($urandom_range(0, 2) == 0 || stim_q.size() == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    stim_done = 1'b1;
  end

  // receiver stall pattern and one long hold-off
  initial begin
    int unsigned k;
    k = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      k++;
      if (k == 300) begin
        out_ready_i <= 1'b0;
        repeat (60) @(posedge clk_i);
      end
      out_ready_i <= (k % 400 < 150) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // checker
  always @(posedge clk_i) begin
    lex_res_t e;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (token_q.size() == 0) begin
        report("unexpected transaction", 32'(token_kind_o), 32'd0);
      end else begin
        e = token_q.pop_front();
        if (result_kind_o != e.kind)
          report("result_kind", 32'(result_kind_o), 32'(e.kind));
        if (token_kind_o != e.tk) report("token_kind", 32'(token_kind_o), 32'(e.tk));
        if (token_value_o != e.value) report("token_value", token_value_o, e.value);
        if (text_char_o != e.ch) report("text_char", 32'(text_char_o), 32'(e.ch));
        if (last_of_step_o != e.last)
          report("last_of_step", 32'(last_of_step_o), 32'(e.last));
      end
    end
  end

  initial begin
    wait (stim_done);
    while (token_q.size() > 0 && cycles < 400000) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (cycles >= 400000) begin
      $display("SCOREBOARD MISMATCH");
    end else if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    wait (cycles >= 500000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
